// ----- rtl/sbus_pkg.sv -----
// ----------------------------------------------------------------------------
// SBUS receiver package
// Shared constants, register indexes and types for the SBUS frame receiver.
// ----------------------------------------------------------------------------
package sbus_pkg;

  localparam int unsigned FRAME_BYTES   = 25;
  localparam int unsigned CHANNEL_COUNT = 6;
  localparam int unsigned GAP_LIMIT_US  = 3000;
  localparam int unsigned FILTER_COUNT  = 3;

  // The last frame byte is never stored: it arrives with the frame check.
  localparam int unsigned CELL_COUNT = FRAME_BYTES - 1;
  localparam int unsigned FLAG_BYTE  = 23;
  localparam int unsigned CH_FIELDS  = 6;
  localparam int unsigned CH_W       = 11;
  localparam int unsigned CH_SEL_W   = 3;
  localparam int unsigned IDX_W      = $clog2(FRAME_BYTES);

  localparam logic [31:0] IDLE_CAP     = 32'hFFFF_0000;
  localparam logic [31:0] GAP_LIMIT    = 32'(GAP_LIMIT_US);
  localparam logic [1:0]  FILTER_LIMIT = 2'(FILTER_COUNT);

  // Register reset values
  localparam logic [15:0] LOST_TIMEOUT_RST = 16'd100;
  localparam logic [2:0]  SW_CHANNEL_RST   = 3'd4;
  localparam logic [10:0] SW_LOW_RST       = 11'd200;
  localparam logic [10:0] SW_MID_RST       = 11'd1000;
  localparam logic [10:0] SW_HIGH_RST      = 11'd1800;
  localparam logic [7:0]  HEAD_BYTE_RST    = 8'h0F;
  localparam logic [7:0]  END_BYTE_RST     = 8'h00;
  localparam logic [7:0]  FS_MASK_RST      = 8'h04;

  typedef enum logic [2:0] {
    CFG_LOST_TIMEOUT = 3'd0,
    CFG_SW_CHANNEL   = 3'd1,
    CFG_SW_LOW       = 3'd2,
    CFG_SW_MID       = 3'd3,
    CFG_SW_HIGH      = 3'd4,
    CFG_HEAD_BYTE    = 3'd5,
    CFG_END_BYTE     = 3'd6,
    CFG_FS_MASK      = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    SW_LOW  = 2'd0,
    SW_MID  = 2'd1,
    SW_HIGH = 2'd2
  } sw_pos_e;

  typedef struct packed {
    logic [CH_W-1:0] low;
    logic [CH_W-1:0] mid;
    logic [CH_W-1:0] high;
  } sw_cal_t;

  typedef struct packed {
    logic tick;
    logic online;
  } sw_ctrl_t;

endpackage

// ----- rtl/sbus_cell.sv -----
// ----------------------------------------------------------------------------
// SBUS byte cell
// One byte of the frame shift line; takes its neighbor's byte on each beat.
// ----------------------------------------------------------------------------
module sbus_cell
  import sbus_pkg::*;
(
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  output logic [7:0] byte_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  assign byte_d = shift_i ? byte_i : byte_q;
  assign byte_o = byte_q;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

// ----- rtl/sbus_switch.sv -----
// ----------------------------------------------------------------------------
// SBUS switch filter
// Nearest calibration point decode and three-in-a-row filter of the switch.
// ----------------------------------------------------------------------------
module sbus_switch
  import sbus_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sw_ctrl_t        ctrl_i,
  input  logic [CH_W-1:0] raw_i,
  input  sw_cal_t         cal_i,
  output logic [1:0]      pos_d_o,
  output logic [1:0]      pos_q_o
);

  logic [CH_W-1:0] dist_low;
  logic [CH_W-1:0] dist_mid;
  logic [CH_W-1:0] dist_high;
  sw_pos_e         pos;
  sw_pos_e         state_q, state_d;
  sw_pos_e         cand_q, cand_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [1:0]      cnt_inc;

  assign dist_low  = (raw_i >= cal_i.low)  ? raw_i - cal_i.low  : cal_i.low  - raw_i;
  assign dist_mid  = (raw_i >= cal_i.mid)  ? raw_i - cal_i.mid  : cal_i.mid  - raw_i;
  assign dist_high = (raw_i >= cal_i.high) ? raw_i - cal_i.high : cal_i.high - raw_i;

  // Ties prefer low, then high, then middle.
  always_comb begin
    if (dist_low <= dist_mid && dist_low <= dist_high) begin
      pos = SW_LOW;
    end else if (dist_high <= dist_mid && dist_high <= dist_low) begin
      pos = SW_HIGH;
    end else begin
      pos = SW_MID;
    end
  end

  assign cnt_inc = cnt_q + 2'd1;

  always_comb begin
    state_d = state_q;
    cand_d  = cand_q;
    cnt_d   = cnt_q;
    if (ctrl_i.tick) begin
      if (ctrl_i.online) begin
        if (pos == cand_q) begin
          cnt_d = cnt_inc;
          if (cnt_inc >= FILTER_LIMIT) begin
            state_d = pos;
            cnt_d   = FILTER_LIMIT;
          end
        end else begin
          cand_d = pos;
          cnt_d  = 2'd1;
        end
      end else begin
        // drop to low while the link is down
        state_d = SW_LOW;
        cand_d  = SW_LOW;
        cnt_d   = 2'd0;
      end
    end
  end

  assign pos_d_o = state_d;
  assign pos_q_o = state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SW_LOW;
      cand_q  <= SW_LOW;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      cand_q  <= cand_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/sbus_receiver_with_failsafe_unit.sv -----
// ----------------------------------------------------------------------------
// SBUS receiver with failsafe
// Results are registered, or held in the skid stage while the output stalls.
// Throughput: one beat per cycle while not stalled, bytes and ticks alike;
// bounded by the frame update and the idle timer add and compare on ticks.
// Reset: asynchronous, active low; clears all control state and registers,
// idle timer starts at the reset timeout plus one. No clearing pass.
// ----------------------------------------------------------------------------
module sbus_receiver_with_failsafe_unit
  import sbus_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [31:0]         time_us_i,
  input  logic [15:0]         elapsed_ms_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                frame_accepted_o,
  output logic [CH_W-1:0]     channel_a_o,
  output logic [CH_W-1:0]     channel_b_o,
  output logic [CH_W-1:0]     channel_c_o,
  output logic [CH_W-1:0]     channel_d_o,
  output logic [CH_W-1:0]     channel_e_o,
  output logic [CH_W-1:0]     channel_f_o,
  output logic                receiver_ok_o,
  output logic                link_online_o,
  output logic [1:0]          switch_position_o,
  output logic [31:0]         frame_total_o
);

  typedef struct packed {
    logic            accepted;
    logic [CH_W-1:0] ch_a;
    logic [CH_W-1:0] ch_b;
    logic [CH_W-1:0] ch_c;
    logic [CH_W-1:0] ch_d;
    logic [CH_W-1:0] ch_e;
    logic [CH_W-1:0] ch_f;
    logic            rx_ok;
    logic            online;
    logic [1:0]      sw_pos;
    logic [31:0]     frames;
  } res_t;

  // configuration registers
  logic [15:0]     timeout_q;
  logic [2:0]      sw_chan_q;
  sw_cal_t         cal_q;
  logic [7:0]      head_q;
  logic [7:0]      end_q;
  logic [7:0]      fs_mask_q;

  // frame and link state
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [31:0]      prev_time_q, prev_time_d;
  logic [CH_W-1:0]  ch_q [CH_FIELDS];
  logic [CH_W-1:0]  ch_d [CH_FIELDS];
  logic             rx_ok_q, rx_ok_d;
  logic [31:0]      frames_q, frames_d;
  logic [31:0]      idle_q, idle_d;
  logic             online_q, online_d;

  // handshake and result buffer
  logic             in_acc;
  logic             out_take;
  logic             byte_acc;
  logic             tick_acc;
  res_t             res;
  res_t             out_q;
  res_t             skid_q;
  logic             out_valid_q;
  logic             skid_valid_q;

  // frame datapath
  logic [7:0]       cell_byte [CELL_COUNT];
  logic [7:0]       fb [1:9];
  logic [CH_W-1:0]  unpack [CH_FIELDS];
  logic [31:0]      gap;
  logic [IDX_W-1:0] idx_base;
  logic [IDX_W-1:0] idx_inc;
  logic             frame_end;
  logic             frame_ok;
  logic [7:0]       flag_byte;
  logic [31:0]      idle_sum;
  logic [CH_W-1:0]  sw_raw;
  sw_ctrl_t         sw_ctrl;
  logic [1:0]       sw_pos_d;
  logic [1:0]       sw_pos_q;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;
  assign byte_acc   = in_acc && (op_e'(operation_i) == OP_BYTE);
  assign tick_acc   = in_acc && (op_e'(operation_i) == OP_TICK);

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= LOST_TIMEOUT_RST;
      sw_chan_q <= SW_CHANNEL_RST;
      cal_q     <= '{low: SW_LOW_RST, mid: SW_MID_RST, high: SW_HIGH_RST};
      head_q    <= HEAD_BYTE_RST;
      end_q     <= END_BYTE_RST;
      fs_mask_q <= FS_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LOST_TIMEOUT: timeout_q  <= cfg_data_i;
        CFG_SW_CHANNEL:   sw_chan_q  <= cfg_data_i[2:0];
        CFG_SW_LOW:       cal_q.low  <= cfg_data_i[CH_W-1:0];
        CFG_SW_MID:       cal_q.mid  <= cfg_data_i[CH_W-1:0];
        CFG_SW_HIGH:      cal_q.high <= cfg_data_i[CH_W-1:0];
        CFG_HEAD_BYTE:    head_q     <= cfg_data_i[7:0];
        CFG_END_BYTE:     end_q      <= cfg_data_i[7:0];
        CFG_FS_MASK:      fs_mask_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Frame shift line: cell 0 holds the newest byte
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    if (i == 0) begin : g_head
      sbus_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(byte_acc),
        .byte_i (rx_byte_i),
        .byte_o (cell_byte[i])
      );
    end else begin : g_body
      sbus_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(byte_acc),
        .byte_i (cell_byte[i-1]),
        .byte_o (cell_byte[i])
      );
    end
  end

  // frame byte k sits in cell CELL_COUNT-1-k once the last byte arrives
  for (genvar k = 1; k <= 9; k++) begin : g_fb
    assign fb[k] = cell_byte[CELL_COUNT-1-k];
  end

  assign flag_byte = cell_byte[CELL_COUNT-1-FLAG_BYTE];

  assign unpack[0] = {fb[2][2:0], fb[1]};
  assign unpack[1] = {fb[3][5:0], fb[2][7:3]};
  assign unpack[2] = {fb[5][0],   fb[4],      fb[3][7:6]};
  assign unpack[3] = {fb[6][3:0], fb[5][7:1]};
  assign unpack[4] = {fb[7][6:0], fb[6][7:4]};
  assign unpack[5] = {fb[9][1:0], fb[8],      fb[7][7]};

  assign gap       = time_us_i - prev_time_q;
  assign idx_base  = (gap > GAP_LIMIT) ? '0 : idx_q;
  assign idx_inc   = idx_base + IDX_W'(1);
  assign frame_end = (idx_inc == IDX_W'(FRAME_BYTES));
  assign frame_ok  = frame_end && (cell_byte[CELL_COUNT-1] == head_q) && (rx_byte_i == end_q);

  assign idle_sum  = idle_q + {16'd0, elapsed_ms_i};

  always_comb begin
    idx_d       = idx_q;
    prev_time_d = prev_time_q;
    ch_d        = ch_q;
    rx_ok_d     = rx_ok_q;
    frames_d    = frames_q;
    idle_d      = idle_q;
    online_d    = online_q;
    if (byte_acc) begin
      prev_time_d = time_us_i;
      idx_d       = frame_end ? '0 : idx_inc;
      if (frame_ok) begin
        for (int c = 0; c < CH_FIELDS; c++) begin
          if (c < CHANNEL_COUNT) begin
            ch_d[c] = unpack[c];
          end
        end
        rx_ok_d  = ((flag_byte & fs_mask_q) != fs_mask_q);
        frames_d = frames_q + 32'd1;
        idle_d   = '0;
      end
    end
    if (tick_acc) begin
      // hold near the top instead of wrapping
      if (idle_q < IDLE_CAP) begin
        idle_d = idle_sum;
      end
      online_d = (idle_d <= {16'd0, timeout_q}) && rx_ok_q;
    end
  end

  // --------------------------------------------------------------------------
  // Switch filter
  // --------------------------------------------------------------------------
  assign sw_raw  = (32'(sw_chan_q) < CHANNEL_COUNT) ? ch_q[sw_chan_q] : '0;
  assign sw_ctrl = '{tick: tick_acc, online: online_d};

  sbus_switch u_switch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sw_ctrl),
    .raw_i  (sw_raw),
    .cal_i  (cal_q),
    .pos_d_o(sw_pos_d),
    .pos_q_o(sw_pos_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      prev_time_q <= '0;
      for (int c = 0; c < CH_FIELDS; c++) begin
        ch_q[c] <= '0;
      end
      rx_ok_q     <= 1'b0;
      frames_q    <= '0;
      idle_q      <= {16'd0, LOST_TIMEOUT_RST} + 32'd1;
      online_q    <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      prev_time_q <= prev_time_d;
      ch_q        <= ch_d;
      rx_ok_q     <= rx_ok_d;
      frames_q    <= frames_d;
      idle_q      <= idle_d;
      online_q    <= online_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result beat: output register plus skid stage
  // --------------------------------------------------------------------------
  always_comb begin
    res.accepted = byte_acc && frame_ok;
    res.ch_a     = ch_d[0];
    res.ch_b     = ch_d[1];
    res.ch_c     = ch_d[2];
    res.ch_d     = ch_d[3];
    res.ch_e     = ch_d[4];
    res.ch_f     = ch_d[5];
    res.rx_ok    = rx_ok_d;
    res.online   = online_d;
    res.sw_pos   = sw_pos_d;
    res.frames   = frames_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_take || !out_valid_q) begin
        out_valid_q  <= skid_valid_q || in_acc;
        skid_valid_q <= 1'b0;
      end else if (in_acc) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res;
    end
    if (in_acc && out_valid_q && !out_take) begin
      skid_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_accepted_o  = out_q.accepted;
  assign channel_a_o       = out_q.ch_a;
  assign channel_b_o       = out_q.ch_b;
  assign channel_c_o       = out_q.ch_c;
  assign channel_d_o       = out_q.ch_d;
  assign channel_e_o       = out_q.ch_e;
  assign channel_f_o       = out_q.ch_f;
  assign receiver_ok_o     = out_q.rx_ok;
  assign link_online_o     = out_q.online;
  assign switch_position_o = out_q.sw_pos;
  assign frame_total_o     = out_q.frames;

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < IDX_W'(FRAME_BYTES))
    else $error("byte index beyond frame length");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a beat ahead of the output register");

  a_frame_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_acc && frame_ok) |=> (frames_q == $past(frames_q) + 32'd1))
    else $error("valid frame did not advance the frame count");

  a_offline_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_acc && !online_d) |=> (sw_pos_q == SW_LOW))
    else $error("switch not forced low while offline");
`endif

endmodule

// ----- verif/sbus_receiver_with_failsafe_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SBUS receiver with failsafe: block-level testbench
// Drives received bytes and poll ticks through the valid/stall input channel
// and checks every status beat against an in-bench frame decoder, or typed
// rows' own answers. The run walks a directed table first, then random
// frame traffic under a series of register settings, then a short run of
// long ticks under the widest timeout. Both channels idle and stall at
// random; the receiver once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module sbus_receiver_with_failsafe_unit_tb;
  import sbus_pkg::*;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [2:0]  sw_chan;
    logic [10:0] low_pt;
    logic [10:0] mid_pt;
    logic [10:0] high_pt;
    logic [7:0]  head;
    logic [7:0]  tail;
    logic [7:0]  fs_mask;
  } link_cfg_t;

  typedef struct packed {
    logic                       acc;
    logic [5:0][CH_W-1:0]       ch;
    logic                       ok;
    logic                       online;
    logic [1:0]                 sw;
    logic [31:0]                total;
  } status_t;

  typedef enum logic [2:0] {
    ROW_BYTE,
    ROW_TICK,
    ROW_FRAME,
    ROW_BAD_HEAD,
    ROW_BAD_END
  } row_kind_e;

  // For frame rows, stamp is the step between bytes; fill goes to bytes 1..22.
  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  fill;
    logic [7:0]  flag;
    logic [31:0] stamp;
    logic [15:0] ms;
    logic        typed;
    status_t     want;
  } dir_row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HALF,
    RX_HEAVY
  } rx_mode_e;

  // DUT connections
  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        cfg_we       = 1'b0;
  logic [2:0]  cfg_idx      = '0;
  logic [15:0] cfg_data     = '0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic        operation    = OP_BYTE;
  logic [7:0]  rx_byte      = '0;
  logic [31:0] time_us      = '0;
  logic [15:0] elapsed_ms   = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic        frame_accepted;
  logic [CH_W-1:0] channel_a, channel_b, channel_c, channel_d, channel_e, channel_f;
  logic        receiver_ok;
  logic        link_online;
  logic [1:0]  switch_position;
  logic [31:0] frame_total;

  // Decoder state
  link_cfg_t   cfg;
  frame_t      frame_bytes;
  int unsigned wr_pos;
  logic [31:0] last_stamp;
  logic [5:0][CH_W-1:0] chan;
  logic        rx_ok;
  logic [31:0] frame_count;
  logic [31:0] idle_ms;
  logic        online;
  sw_pos_e     sw_taken;
  sw_pos_e     sw_cand;
  logic [1:0]  sw_run;

  status_t     status_due [$];
  dir_row_t    rows [$];
  logic [31:0] now_us     = '0;
  int unsigned beats_in   = 0;
  int unsigned burst_left = 0;
  int          errors     = 0;

  // Receiver stall pattern
  int          hold_left  = 0;
  bit          hold_done  = 1'b0;
  int          mode_left  = 0;
  rx_mode_e    rx_mode    = RX_OPEN;

  status_t     owed;
  status_t     seen;

  sbus_receiver_with_failsafe_unit u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .operation_i       (operation),
    .rx_byte_i         (rx_byte),
    .time_us_i         (time_us),
    .elapsed_ms_i      (elapsed_ms),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .frame_accepted_o  (frame_accepted),
    .channel_a_o       (channel_a),
    .channel_b_o       (channel_b),
    .channel_c_o       (channel_c),
    .channel_d_o       (channel_d),
    .channel_e_o       (channel_e),
    .channel_f_o       (channel_f),
    .receiver_ok_o     (receiver_ok),
    .link_online_o     (link_online),
    .switch_position_o (switch_position),
    .frame_total_o     (frame_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sw_pos_e closest_detent(logic [10:0] raw);
    logic [10:0] dl, dm, dh;
    dl = (raw >= cfg.low_pt)  ? raw - cfg.low_pt  : cfg.low_pt - raw;
    dm = (raw >= cfg.mid_pt)  ? raw - cfg.mid_pt  : cfg.mid_pt - raw;
    dh = (raw >= cfg.high_pt) ? raw - cfg.high_pt : cfg.high_pt - raw;
    // ties go low first, then high
    if (dl <= dm && dl <= dh) return SW_LOW;
    if (dh <= dm && dh <= dl) return SW_HIGH;
    return SW_MID;
  endfunction

  function automatic status_t decode_beat(op_e op, logic [7:0] b, logic [31:0] t,
                                          logic [15:0] ms);
    logic [31:0] gap;
    logic [71:0] bits;
    logic [10:0] raw;
    sw_pos_e     pos;
    status_t     r;
    r.acc = 1'b0;
    if (op == OP_BYTE) begin
      gap = t - last_stamp;
      last_stamp = t;
      if (gap > GAP_LIMIT) wr_pos = 0;
      if (wr_pos >= FRAME_BYTES) wr_pos = 0;
      frame_bytes[wr_pos] = b;
      wr_pos++;
      if (wr_pos >= FRAME_BYTES) begin
        if (frame_bytes[0] == cfg.head && frame_bytes[FRAME_BYTES-1] == cfg.tail) begin
          // channels are packed LSB first from byte 1 on
          for (int k = 0; k < 9; k++) bits[8*k +: 8] = frame_bytes[k+1];
          for (int k = 0; k < CH_FIELDS; k++) chan[k] = bits[CH_W*k +: CH_W];
          rx_ok = (frame_bytes[FLAG_BYTE] & cfg.fs_mask) != cfg.fs_mask;
          frame_count = frame_count + 32'd1;
          idle_ms = '0;
          r.acc = 1'b1;
        end
        wr_pos = 0;
      end
    end else begin
      if (idle_ms < IDLE_CAP) idle_ms = idle_ms + 32'(ms);
      online = (idle_ms <= 32'(cfg.timeout_ms)) && rx_ok;
      if (online) begin
        raw = (cfg.sw_chan < CHANNEL_COUNT) ? chan[cfg.sw_chan] : '0;
        pos = closest_detent(raw);
        if (pos == sw_cand) begin
          sw_run = sw_run + 2'd1;
          if (sw_run >= FILTER_LIMIT) begin
            sw_taken = pos;
            sw_run = FILTER_LIMIT;
          end
        end else begin
          sw_cand = pos;
          sw_run = 2'd1;
        end
      end else begin
        sw_taken = SW_LOW;
        sw_cand = SW_LOW;
        sw_run = '0;
      end
    end
    r.ch = chan;
    r.ok = rx_ok;
    r.online = online;
    r.sw = sw_taken;
    r.total = frame_count;
    return r;
  endfunction

  function automatic status_t flat_result(logic acc, logic [10:0] chv, logic ok,
                                          logic on, sw_pos_e sw, logic [31:0] tot);
    status_t r;
    r.acc = acc;
    r.ch = {6{chv}};
    r.ok = ok;
    r.online = on;
    r.sw = sw;
    r.total = tot;
    return r;
  endfunction

  function automatic frame_t framed(logic [7:0] fill, logic [7:0] flag, row_kind_e kind);
    frame_t f;
    f = {FRAME_BYTES{fill}};
    f[0] = (kind == ROW_BAD_HEAD) ? ~cfg.head : cfg.head;
    f[FLAG_BYTE] = flag;
    f[FRAME_BYTES-1] = (kind == ROW_BAD_END) ? ~cfg.tail : cfg.tail;
    return f;
  endfunction

  function automatic frame_t random_body();
    frame_t f;
    int     r;
    for (int k = 0; k < FRAME_BYTES; k++) f[k] = 8'($urandom);
    r = $urandom_range(0, 2);
    if (r == 1) f[FLAG_BYTE] = f[FLAG_BYTE] | cfg.fs_mask;
    if (r == 2) f[FLAG_BYTE] = f[FLAG_BYTE] & ~cfg.fs_mask;
    if ($urandom_range(0, 9) != 0) f[0] = cfg.head;
    if ($urandom_range(0, 9) != 0) f[FRAME_BYTES-1] = cfg.tail;
    return f;
  endfunction

  function automatic logic [15:0] pick_elapsed();
    if ($urandom_range(0, 9) < 7) return 16'($urandom_range(0, cfg.timeout_ms / 8));
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, GAP_LIMIT - 1);
    if (r < 85) return GAP_LIMIT;
    if (r < 93) return '0;
    return $urandom_range(GAP_LIMIT + 1, 20000);
  endfunction

  task automatic send_beat(input op_e op, input logic [7:0] b, input logic [31:0] t,
                           input logic [15:0] ms, input logic typed, input status_t want);
    int      gap;
    status_t pred;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    rx_byte    <= b;
    time_us    <= t;
    elapsed_ms <= ms;
    do @(posedge clk); while (in_stall);
    burst_left--;
    beats_in++;
    pred = decode_beat(op, b, t, ms);
    status_due.push_back(typed ? want : pred);
  endtask

  task automatic send_tick(input logic [15:0] ms);
    send_beat(OP_TICK, 8'($urandom), $urandom, ms, 1'b0, '0);
  endtask

  // First byte lands past the gap limit so collection always restarts there.
  task automatic send_frame(input frame_t body, input logic [31:0] step, input int tick_pct,
                            input logic typed, input status_t want);
    for (int k = 0; k < FRAME_BYTES; k++) begin
      if (k == 0) begin
        now_us = now_us + GAP_LIMIT + 32'd1;
      end else begin
        if ($urandom_range(0, 99) < tick_pct) send_tick(pick_elapsed());
        now_us = now_us + step;
      end
      send_beat(OP_BYTE, body[k], now_us, 16'($urandom), typed && k == FRAME_BYTES - 1, want);
    end
  endtask

  task automatic write_all(input link_cfg_t s);
    cfg_we <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      cfg_idx <= cfg_idx_e'(i);
      case (cfg_idx_e'(i))
        CFG_LOST_TIMEOUT: cfg_data <= s.timeout_ms;
        CFG_SW_CHANNEL:   cfg_data <= 16'(s.sw_chan);
        CFG_SW_LOW:       cfg_data <= 16'(s.low_pt);
        CFG_SW_MID:       cfg_data <= 16'(s.mid_pt);
        CFG_SW_HIGH:      cfg_data <= 16'(s.high_pt);
        CFG_HEAD_BYTE:    cfg_data <= 16'(s.head);
        CFG_END_BYTE:     cfg_data <= 16'(s.tail);
        CFG_FS_MASK:      cfg_data <= 16'(s.fs_mask);
        default:          cfg_data <= '0;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg = s;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic run_traffic(input int unsigned n);
    int unsigned start;
    int          r;
    start = beats_in;
    while (beats_in - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if ($urandom_range(0, 3) == 0) now_us = $urandom;
        send_frame(random_body(), pick_step(), 8, 1'b0, '0);
      end else if (r < 85) begin
        repeat ($urandom_range(1, 5)) send_tick(pick_elapsed());
      end else begin
        // stray bytes with arbitrary spacing
        repeat ($urandom_range(1, 4)) begin
          now_us = now_us + (($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 4000));
          send_beat(OP_BYTE, 8'($urandom), now_us, 16'($urandom), 1'b0, '0);
        end
      end
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // Receiver: stall on random stretches; hold off once to back the block up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && beats_in >= 300) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
        default:  out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.acc    = frame_accepted;
      seen.ch     = {channel_f, channel_e, channel_d, channel_c, channel_b, channel_a};
      seen.ok     = receiver_ok;
      seen.online = link_online;
      seen.sw     = switch_position;
      seen.total  = frame_total;
      if (status_due.size() == 0) begin
        $display("%0t: status beat with nothing outstanding, frame_total %0d",
                 $time, frame_total);
        errors++;
      end else begin
        owed = status_due.pop_front();
        check_field("frame_accepted", 32'(owed.acc), 32'(seen.acc));
        for (int k = 0; k < CH_FIELDS; k++)
          check_field($sformatf("channel %0d", k), 32'(owed.ch[k]), 32'(seen.ch[k]));
        check_field("receiver_ok", 32'(owed.ok), 32'(seen.ok));
        check_field("link_online", 32'(owed.online), 32'(seen.online));
        check_field("switch_position", 32'(owed.sw), 32'(seen.sw));
        check_field("frame_total", owed.total, seen.total);
      end
    end
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    dir_row_t  row;
    link_cfg_t plan [$];
    link_cfg_t sat_cfg;
    status_t   z;

    cfg = '{LOST_TIMEOUT_RST, SW_CHANNEL_RST, SW_LOW_RST, SW_MID_RST, SW_HIGH_RST,
            HEAD_BYTE_RST, END_BYTE_RST, FS_MASK_RST};
    frame_bytes = '0;
    wr_pos      = 0;
    last_stamp  = '0;
    chan        = '0;
    rx_ok       = 1'b0;
    frame_count = '0;
    idle_ms     = 32'(LOST_TIMEOUT_RST) + 32'd1;
    online      = 1'b0;
    sw_taken    = SW_LOW;
    sw_cand     = SW_LOW;
    sw_run      = '0;

    // Directed table, reset register values. Typed rows carry their own answer.
    z = flat_result(1'b0, 11'd0, 1'b0, 1'b0, SW_LOW, 32'd2);
    rows.push_back('{ROW_TICK, 8'h00, 8'h00, 32'h0, 16'h0000, 1'b1,
                     flat_result(1'b0, 11'd0, 1'b0, 1'b0, SW_LOW, 32'd0)});
    rows.push_back('{ROW_TICK, 8'h00, 8'h00, 32'h0, 16'hFFFF, 1'b1,
                     flat_result(1'b0, 11'd0, 1'b0, 1'b0, SW_LOW, 32'd0)});
    rows.push_back('{ROW_BYTE, 8'hFF, 8'h00, 32'hFFFF_F000, 16'h0, 1'b1,
                     flat_result(1'b0, 11'd0, 1'b0, 1'b0, SW_LOW, 32'd0)});
    // all-ones body straddling the timestamp wrap
    rows.push_back('{ROW_FRAME, 8'hFF, 8'h00, 32'd1000, 16'h0, 1'b1,
                     flat_result(1'b1, 11'h7FF, 1'b1, 1'b0, SW_LOW, 32'd1)});
    rows.push_back('{ROW_TICK, 8'h00, 8'h00, 32'h0, 16'd0, 1'b1,
                     flat_result(1'b0, 11'h7FF, 1'b1, 1'b1, SW_LOW, 32'd1)});
    rows.push_back('{ROW_TICK, 8'h00, 8'h00, 32'h0, 16'd0, 1'b1,
                     flat_result(1'b0, 11'h7FF, 1'b1, 1'b1, SW_LOW, 32'd1)});
    rows.push_back('{ROW_TICK, 8'h00, 8'h00, 32'h0, 16'd0, 1'b1,
                     flat_result(1'b0, 11'h7FF, 1'b1, 1'b1, SW_HIGH, 32'd1)});
    // idle exactly at the timeout stays online, one more ms drops it
    rows.push_back('{ROW_TICK, 8'h00, 8'h00, 32'h0, 16'd100, 1'b1,
                     flat_result(1'b0, 11'h7FF, 1'b1, 1'b1, SW_HIGH, 32'd1)});
    rows.push_back('{ROW_TICK, 8'h00, 8'h00, 32'h0, 16'd1, 1'b1,
                     flat_result(1'b0, 11'h7FF, 1'b1, 1'b0, SW_LOW, 32'd1)});
    // gap of exactly the limit keeps collecting; failsafe flag set
    rows.push_back('{ROW_FRAME, 8'h00, 8'h04, GAP_LIMIT, 16'h0, 1'b1,
                     flat_result(1'b1, 11'd0, 1'b0, 1'b0, SW_LOW, 32'd2)});
    rows.push_back('{ROW_TICK, 8'h00, 8'h00, 32'h0, 16'd0, 1'b1, z});
    rows.push_back('{ROW_BAD_HEAD, 8'h55, 8'h00, 32'd1, 16'h0, 1'b1, z});
    rows.push_back('{ROW_BAD_END, 8'hAA, 8'h00, 32'd1, 16'h0, 1'b1, z});
    // every byte past the gap limit: nothing ever completes
    rows.push_back('{ROW_FRAME, 8'h55, 8'hFB, GAP_LIMIT + 32'd1, 16'h0, 1'b1, z});
    rows.push_back('{ROW_BYTE, 8'h00, 8'h00, 32'h0000_0000, 16'h0, 1'b1, z});
    rows.push_back('{ROW_FRAME, 8'h5A, 8'hFF, 32'd0, 16'h0, 1'b0, z});
    rows.push_back('{ROW_FRAME, 8'hA5, 8'h00, 32'd2999, 16'h0, 1'b0, z});
    rows.push_back('{ROW_TICK, 8'h00, 8'h00, 32'h0, 16'd0, 1'b0, z});
    rows.push_back('{ROW_TICK, 8'h00, 8'h00, 32'h0, 16'd0, 1'b0, z});
    rows.push_back('{ROW_TICK, 8'h00, 8'h00, 32'h0, 16'd0, 1'b0, z});
    rows.push_back('{ROW_TICK, 8'h00, 8'h00, 32'h0, 16'hFFFF, 1'b0, z});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      case (row.kind)
        ROW_BYTE: begin
          now_us = row.stamp;
          send_beat(OP_BYTE, row.fill, row.stamp, 16'($urandom), row.typed, row.want);
        end
        ROW_TICK: begin
          send_beat(OP_TICK, 8'($urandom), $urandom, row.ms, row.typed, row.want);
        end
        default: begin
          send_frame(framed(row.fill, row.flag, row.kind), row.stamp, 0, row.typed, row.want);
        end
      endcase
    end

    // Register settings: widest timeout, mask zero, and switch ties with the
    // channel index past the last channel (raw reads as zero).
    plan.push_back('{16'hFFFF, 3'd0, 11'd0,    11'd1024, 11'd2047, 8'h0F, 8'h00, 8'h04});
    plan.push_back('{16'h0000, 3'd5, 11'd2047, 11'd0,    11'd1000, 8'hFF, 8'hFF, 8'h00});
    plan.push_back('{16'd300,  3'd7, 11'd50,   11'd2047, 11'd50,   8'h00, 8'hFF, 8'hFF});
    plan.push_back('{16'd1000, 3'd6, 11'd2047, 11'd60,   11'd60,   8'hA5, 8'h5A, 8'h80});
    plan.push_back('{16'd5000, 3'd7, 11'd70,   11'd70,   11'd2047, 8'h3C, 8'hC3, 8'h0C});
    repeat (2) plan.push_back('{16'($urandom), 3'($urandom), 11'($urandom), 11'($urandom),
                                11'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)});
    foreach (plan[p]) begin
      settle();
      write_all(plan[p]);
      run_traffic(50);
    end

    // Long ticks under the widest timeout: the link drops after the second one.
    sat_cfg = '{16'hFFFF, 3'd2, SW_LOW_RST, SW_MID_RST, SW_HIGH_RST,
                HEAD_BYTE_RST, END_BYTE_RST, FS_MASK_RST};
    settle();
    write_all(sat_cfg);
    send_frame(framed(8'h3C, 8'h00, ROW_FRAME), 32'd500, 0, 1'b0, '0);
    repeat (20) send_tick(16'hFFFF);
    repeat (6) send_tick(pick_elapsed());

    settle();
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sbus_pkg.sv
rtl/sbus_cell.sv
rtl/sbus_switch.sv
rtl/sbus_receiver_with_failsafe_unit.sv
verif/sbus_receiver_with_failsafe_unit_tb.sv
